// ===== rtl/core/msk_pkg.sv =====
// Package for the minimum-tracking stack: controller states, status codes,
// operation kinds and the layout of one stored entry. No dependencies.
`default_nettype none

package msk_pkg;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  localparam logic       KIND_PUSH  = 1'b0;
  localparam logic       KIND_POP   = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned COUNT_W   = 9;

  // Each slot keeps its value and the minimum of itself and every slot below.
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic signed [VAL_W-1:0] pmin;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/min_tracking_stack.sv =====
// Minimum-tracking stack: a LIFO of signed 32-bit values that reports top,
// minimum, count and status after every item. Depends on msk_pkg and msk_ram.
// ST_IDLE accepts an item and accesses the entry memory; ST_EMIT loads the result
// register once the output is free, and no new item is accepted before that. The
// registered read of the memory is why the result is loaded in a state of its own.
// Reset (rst_n low, synchronous) empties the stack; memory contents are not cleared.
`default_nettype none

module min_tracking_stack #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic                                in_kind,
  input  wire logic signed [msk_pkg::VAL_W-1:0]    in_value,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic signed [msk_pkg::VAL_W-1:0]    out_top_value,
  output      logic signed [msk_pkg::VAL_W-1:0]    out_min_value,
  output      logic [msk_pkg::COUNT_W-1:0]         out_entry_count,
  output      logic                                out_is_empty,
  output      logic [1:0]                          out_status
);

  import msk_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = $bits(entry_t);

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic signed [VAL_W-1:0] top_r, top_nxt;
  logic signed [VAL_W-1:0] min_r, min_nxt;
  logic [1:0]              status_r, status_nxt;
  logic                    rd_pend_r, rd_pend_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_top_r, out_top_nxt;
  logic signed [VAL_W-1:0] out_min_r, out_min_nxt;
  logic [COUNT_W-1:0]      out_count_r, out_count_nxt;
  logic                    out_empty_r, out_empty_nxt;
  logic [1:0]              out_status_r, out_status_nxt;

  logic                    mem_we;
  logic                    mem_re;
  logic [AW-1:0]           mem_waddr;
  logic [AW-1:0]           mem_raddr;
  entry_t                  mem_wdata;
  entry_t                  mem_rdata;
  logic signed [VAL_W-1:0] push_min;

  msk_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign push_min  = (count_r == '0 || in_value < min_r) ? in_value : min_r;
  assign mem_waddr = count_r[AW-1:0];
  assign mem_raddr = AW'(count_r - CW'(2));
  assign mem_wdata = '{val: in_value, pmin: push_min};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    top_nxt        = top_r;
    min_nxt        = min_r;
    status_nxt     = status_r;
    rd_pend_nxt    = rd_pend_r;
    out_valid_nxt  = out_valid_r;
    out_top_nxt    = out_top_r;
    out_min_nxt    = out_min_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt   = ST_EMIT;
          rd_pend_nxt = 1'b0;
          status_nxt  = STAT_OK;
          if (in_kind == KIND_PUSH) begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = STAT_FULL;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
              top_nxt   = in_value;
              min_nxt   = push_min;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = STAT_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
              if (count_r == CW'(1)) begin
                top_nxt = '0;
                min_nxt = '0;
              end else begin
                mem_re      = 1'b1;
                rd_pend_nxt = 1'b1;
              end
            end
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = COUNT_W'(count_r);
          out_empty_nxt  = (count_r == '0);
          out_status_nxt = status_r;
          if (rd_pend_r) begin
            top_nxt     = mem_rdata.val;
            min_nxt     = mem_rdata.pmin;
            out_top_nxt = mem_rdata.val;
            out_min_nxt = mem_rdata.pmin;
          end else begin
            out_top_nxt = top_r;
            out_min_nxt = min_r;
          end
          rd_pend_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      top_r       <= '0;
      min_r       <= '0;
      status_r    <= STAT_OK;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      top_r       <= top_nxt;
      min_r       <= min_nxt;
      status_r    <= status_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_top_r    <= out_top_nxt;
    out_min_r    <= out_min_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_min_value   = out_min_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_status      = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/core/msk_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. No dependencies.
`default_nettype none

module msk_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/min_tracking_stack_tb.sv =====
// Testbench for min_tracking_stack: drives push and pop items, predicts top,
// minimum, count, empty flag and status, and checks every result item.
// Depends on msk_pkg and the min_tracking_stack RTL.
`timescale 1ns / 1ps

module min_tracking_stack_tb;
  import msk_pkg::*;

  localparam int unsigned STACK_DEPTH    = 256;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [31:0] VAL_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN        = 32'h8000_0000;

  localparam int VM_FULL   = 0;
  localparam int VM_NARROW = 1;
  localparam int VM_EDGE   = 2;
  localparam int VM_FALL   = 3;

  localparam int RX_OPEN     = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_SPARSE   = 2;
  localparam int RX_PERIODIC = 3;

  typedef struct {
    logic        kind;
    logic [31:0] value;
    bit          drain;
  } stack_op_t;

  typedef struct {
    logic signed [VAL_W-1:0]   top_value;
    logic signed [VAL_W-1:0]   min_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    logic [1:0]                status;
  } stack_view_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_kind;
  logic signed [VAL_W-1:0]   in_value;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [VAL_W-1:0]   out_top_value;
  logic signed [VAL_W-1:0]   out_min_value;
  logic [COUNT_W-1:0]        out_entry_count;
  logic                      out_is_empty;
  logic [1:0]                out_status;

  stack_op_t   pending_ops[$];
  stack_view_t expected_views[$];
  stack_view_t seen_view;
  stack_op_t   next_op;

  logic signed [VAL_W-1:0] model_mem [STACK_DEPTH];
  int unsigned             model_depth;
  logic signed [VAL_W-1:0] model_min;
  bit                      model_min_live;

  int          error_count;
  int          idle_cycles;
  int          op_total;
  bit          took;
  int          burst_left;
  int          gap_left;
  int          rx_mode;
  int          rx_left;
  int unsigned rx_tick;
  logic [31:0] fall_value;

  min_tracking_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_top_value   (out_top_value),
    .out_min_value   (out_min_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void predict_view(logic kind, logic signed [VAL_W-1:0] v);
    stack_view_t             r;
    logic signed [VAL_W-1:0] gone;
    int unsigned             i;
    r.status = STAT_OK;
    if (kind == KIND_PUSH) begin
      if (model_depth >= STACK_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        model_mem[model_depth] = v;
        model_depth++;
        if (!model_min_live || v < model_min) begin
          model_min      = v;
          model_min_live = 1'b1;
        end
      end
    end else begin
      if (model_depth == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        model_depth--;
        gone = model_mem[model_depth];
        if (model_depth == 0) begin
          model_min_live = 1'b0;
        end else if (gone == model_min) begin
          model_min = model_mem[0];
          for (i = 1; i < model_depth; i++) begin
            if (model_mem[i] < model_min) model_min = model_mem[i];
          end
        end
      end
    end
    if (model_depth == 0) begin
      r.top_value = '0;
      r.min_value = '0;
      r.is_empty  = 1'b1;
    end else begin
      r.top_value = model_mem[model_depth-1];
      r.min_value = model_min;
      r.is_empty  = 1'b0;
    end
    r.entry_count = model_depth[COUNT_W-1:0];
    expected_views.push_back(r);
  endfunction

  task automatic add_op(input logic kind, input logic [31:0] v, input bit drain);
    stack_op_t op;
    op.kind  = kind;
    op.value = v;
    op.drain = drain;
    pending_ops.push_back(op);
    op_total++;
  endtask

  task automatic add_walk(input int len, input int push_pct, input int vmode);
    logic [31:0] v;
    int          i;
    for (i = 0; i < len; i++) begin
      case (vmode)
        VM_FULL: begin
          v = $urandom;
        end
        VM_NARROW: begin
          v = $urandom_range(0, 8) - 4;
        end
        VM_EDGE: begin
          case ($urandom_range(0, 4))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = 32'hFFFF_FFFF;
            3: v = VAL_MIN + 1;
            default: v = '0;
          endcase
        end
        default: begin
          v          = fall_value;
          fall_value = fall_value - $urandom_range(0, 3);
        end
      endcase
      add_op(($urandom_range(1, 100) <= push_pct) ? KIND_PUSH : KIND_POP, v,
             (i == 0) && ($urandom_range(0, 3) == 0));
    end
  endtask

  task automatic add_walks_until(input int target);
    int pct;
    while (op_total < target) begin
      case ($urandom_range(0, 2))
        0: pct = 30;
        1: pct = 50;
        default: pct = 70;
      endcase
      fall_value = $urandom;
      add_walk($urandom_range(10, 40), pct, $urandom_range(VM_FULL, VM_FALL));
    end
  endtask

  // Driver: holds an item until it is accepted, then moves to the next one.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() == 0 ||
                   (pending_ops[0].drain && expected_views.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        next_op = pending_ops.pop_front();
        in_kind  <= next_op.kind;
        in_value <= next_op.value;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = $urandom_range(0, 12);
        end else begin
          burst_left--;
        end
      end
    end
  end

  always @(negedge clk) begin
    rx_tick++;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= $urandom_range(0, 1);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_tick % 4 != 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (in_valid && in_ready) begin
        predict_view(in_kind, in_value);
        took = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          $error("unexpected result item: top_value %0d min_value %0d",
                 out_top_value, out_min_value);
          error_count++;
        end else begin
          seen_view = expected_views.pop_front();
          if (out_top_value !== seen_view.top_value) begin
            $error("top_value: expected %0d, got %0d", seen_view.top_value, out_top_value);
            error_count++;
          end
          if (out_min_value !== seen_view.min_value) begin
            $error("min_value: expected %0d, got %0d", seen_view.min_value, out_min_value);
            error_count++;
          end
          if (out_entry_count !== seen_view.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   seen_view.entry_count, out_entry_count);
            error_count++;
          end
          if (out_is_empty !== seen_view.is_empty) begin
            $error("is_empty: expected %0d, got %0d", seen_view.is_empty, out_is_empty);
            error_count++;
          end
          if (out_status !== seen_view.status) begin
            $error("status: expected %0d, got %0d", seen_view.status, out_status);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("min_tracking_stack_tb: errors");
    $finish;
  end

  initial begin
    int i;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_PUSH;
    in_value       = '0;
    out_ready      = 1'b0;
    model_depth    = 0;
    model_min      = '0;
    model_min_live = 1'b0;
    error_count    = 0;
    idle_cycles    = 0;
    op_total       = 0;
    took           = 1'b0;
    burst_left     = $urandom_range(1, 30);
    gap_left       = 0;
    rx_mode        = RX_OPEN;
    rx_left        = 0;
    rx_tick        = 0;
    fall_value     = '0;

    // Extremes, a repeated minimum, pops above and at the minimum, emptying.
    add_op(KIND_PUSH, 32'd0, 1'b0);
    add_op(KIND_PUSH, VAL_MAX, 1'b0);
    add_op(KIND_PUSH, VAL_MIN, 1'b0);
    add_op(KIND_PUSH, 32'hFFFF_FFFF, 1'b0);
    add_op(KIND_PUSH, VAL_MIN, 1'b0);
    add_op(KIND_POP, $urandom, 1'b0);
    add_op(KIND_POP, VAL_MAX, 1'b0);
    add_op(KIND_POP, VAL_MIN, 1'b0);
    add_op(KIND_POP, $urandom, 1'b0);
    add_op(KIND_POP, $urandom, 1'b0);
    add_op(KIND_POP, $urandom, 1'b0);
    add_op(KIND_PUSH, 32'd5, 1'b0);
    add_op(KIND_PUSH, 32'd7, 1'b0);
    add_op(KIND_PUSH, 32'd3, 1'b0);
    add_op(KIND_POP, 32'hFFFF_FFFF, 1'b0);
    add_op(KIND_POP, 32'd0, 1'b0);
    add_op(KIND_POP, 32'd0, 1'b0);
    add_op(KIND_POP, 32'd0, 1'b0);
    add_op(KIND_PUSH, VAL_MAX, 1'b0);
    add_op(KIND_PUSH, VAL_MAX, 1'b0);
    add_op(KIND_POP, 32'd0, 1'b0);
    add_op(KIND_POP, 32'd0, 1'b0);

    add_walks_until(170);
    // Fill past the top so that pushes on a full stack are seen, then back off.
    add_op(KIND_PUSH, $urandom, 1'b1);
    for (i = 0; i < STACK_DEPTH + 3; i++) begin
      add_op(KIND_PUSH, ($urandom_range(0, 1) != 0) ? $urandom : ($urandom_range(0, 8) - 4),
             1'b0);
    end
    for (i = 0; i < 30; i++) begin
      add_op(KIND_POP, $urandom, 1'b0);
    end
    add_walks_until(500);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("min_tracking_stack_tb: clean");
    end else begin
      $display("min_tracking_stack_tb: errors");
    end
    $finish;
  end

endmodule
